FILE: sv/bdp_pkg.sv
// Shared types and constants for the button debounce / press control block.
// No dependencies.
`timescale 1ns / 1ps

package bdp_pkg;

	localparam int unsigned TsW      = 32;
	localparam int unsigned DbW      = 16;
	localparam int unsigned GroupW   = 8;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 16;

	localparam logic [DbW-1:0]    DebounceRst = 16'd50;
	localparam logic [DbW-1:0]    LongRst     = 16'd1000;
	localparam logic [GroupW-1:0] MaxGroupRst = 8'd16;
	localparam logic [GroupW-1:0] GroupFirst  = 8'd1;

	localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE  = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_LONG      = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_MAX_GROUP = 2'd2;

	localparam logic [1:0] MD_LOCAL  = 2'd0;
	localparam logic [1:0] MD_REMOTE = 2'd1;
	localparam logic [1:0] MD_AUTO   = 2'd2;

	localparam logic [1:0] MACT_NONE    = 2'd0;
	localparam logic [1:0] MACT_STOP    = 2'd1;
	localparam logic [1:0] MACT_SPEAKER = 2'd2;

	localparam logic [1:0] PACT_NONE    = 2'd0;
	localparam logic [1:0] PACT_MIC     = 2'd1;
	localparam logic [1:0] PACT_SPEAKER = 2'd2;

	localparam logic [2:0] EV_NONE   = 3'd0;
	localparam logic [2:0] EV_GROUP  = 3'd1;
	localparam logic [2:0] EV_REMOTE = 3'd2;
	localparam logic [2:0] EV_AUTO   = 3'd3;
	localparam logic [2:0] EV_READY  = 3'd4;
	localparam logic [2:0] EV_TX     = 3'd5;

	typedef struct packed {
		logic           fn_level;
		logic           ptt_level;
		logic [TsW-1:0] now_ms;
	} in_req_t;

	typedef struct packed {
		logic [GroupW-1:0] talk_group;
		logic [1:0]        mode;
		logic              ptt_led;
		logic              transmitting;
		logic              receiving_clear;
		logic [1:0]        mode_action;
		logic [1:0]        ptt_action;
		logic [2:0]        status_event;
	} out_req_t;

	typedef struct packed {
		logic [DbW-1:0]    quiet_time;
		logic [DbW-1:0]    hold_time;
		logic [GroupW-1:0] group_max;
	} cfg_t;

	// button part result, handed to the ptt part and the output merge
	typedef struct packed {
		logic [GroupW-1:0] talk_group;
		logic [1:0]        mode;
		logic [1:0]        mode_action;
		logic [2:0]        status_event;
	} btn_res_t;

	typedef struct packed {
		logic       ptt_led;
		logic       transmitting;
		logic       receiving_clear;
		logic [1:0] ptt_action;
		logic [2:0] status_event;
	} ptt_res_t;

endpackage

FILE: sv/button_debounce_press_control_core.sv
// A poll is captured in the input register s1; its result is registered when the
// compute stage fires. One poll per cycle while the result is not stalled; the single
// compute stage between the two registers sets this, and state updates once per poll.
// A stalled result holds the compute stage; with a poll waiting there the input stalls.
// Reset (arst_n low, async): valid flags, state and configuration to defaults, button released, group 1, local.
`timescale 1ns / 1ps

module button_debounce_press_control_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// poll channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  bdp_pkg::in_req_t                    in_data,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output bdp_pkg::out_req_t                   out_data,
	// configuration writes
	input  logic                                cfg_we,
	input  logic [bdp_pkg::CfgIdxW-1:0]         cfg_index,
	input  logic [bdp_pkg::CfgDataW-1:0]        cfg_data
);
	import bdp_pkg::*;

	cfg_t     cfg_q;
	logic     valid_s1;
	in_req_t  req_s1;
	logic     out_valid_q;
	out_req_t out_q;

	logic     adv;
	btn_res_t btn;
	ptt_res_t ptt;
	out_req_t res;

	// Configuration registers; writes past the list fall through.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.quiet_time <= DebounceRst;
			cfg_q.hold_time  <= LongRst;
			cfg_q.group_max  <= MaxGroupRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEBOUNCE:  cfg_q.quiet_time <= cfg_data;
				CFG_LONG:      cfg_q.hold_time  <= cfg_data;
				CFG_MAX_GROUP: cfg_q.group_max  <= cfg_data[GroupW-1:0];
				default: ;
			endcase
		end
	end

	// The compute stage fires when a poll sits in s1 and the result slot is
	// free or being emptied this cycle.
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1 <= in_data;
		end
	end

	bdp_button u_button (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.req    (req_s1),
		.cfg    (cfg_q),
		.res    (btn)
	);

	// ptt sees the mode as left by the button part in the same poll
	bdp_ptt u_ptt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.ptt_level (req_s1.ptt_level),
		.mode      (btn.mode),
		.res       (ptt)
	);

	always_comb begin
		res.talk_group      = btn.talk_group;
		res.mode            = btn.mode;
		res.ptt_led         = ptt.ptt_led;
		res.transmitting    = ptt.transmitting;
		res.receiving_clear = ptt.receiving_clear;
		res.mode_action     = btn.mode_action;
		res.ptt_action      = ptt.ptt_action;
		// push-to-talk status wins over the button status
		res.status_event    = (ptt.status_event != EV_NONE) ? ptt.status_event
		                                                    : btn.status_event;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: sv/bdp_button.sv
// Function button: debounce, short/long press, talk group and mode state.
// Depends on bdp_pkg.
`timescale 1ns / 1ps

module bdp_button (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  bdp_pkg::in_req_t  req,
	input  bdp_pkg::cfg_t     cfg,
	output bdp_pkg::btn_res_t res
);
	import bdp_pkg::*;

	logic              prev_raw_q;
	logic              stable_q;
	logic [TsW-1:0]    change_q;
	logic [TsW-1:0]    press_q;
	logic              long_done_q;
	logic [GroupW-1:0] group_q;
	logic [1:0]        mode_q;

	logic              raw;
	logic [TsW-1:0]    change_n;
	logic [TsW-1:0]    quiet;
	logic              settled;
	logic              stable_n;
	logic [TsW-1:0]    press_n;
	logic              long_done_n;
	logic [GroupW-1:0] group_n;
	logic [1:0]        mode_n;
	logic [1:0]        mact;
	logic [2:0]        ev;
	logic [TsW-1:0]    held;
	logic [GroupW:0]   group_inc;
	logic              go_long;

	always_comb begin
		raw         = req.fn_level;
		change_n    = (raw != prev_raw_q) ? req.now_ms : change_q;
		quiet       = req.now_ms - change_n;
		settled     = quiet > {{(TsW-DbW){1'b0}}, cfg.quiet_time};
		stable_n    = stable_q;
		press_n     = press_q;
		long_done_n = long_done_q;
		group_n     = group_q;
		mode_n      = mode_q;
		mact        = MACT_NONE;
		ev          = EV_NONE;
		group_inc   = {1'b0, group_q} + {{GroupW{1'b0}}, 1'b1};
		held        = req.now_ms - press_q;
		go_long     = 1'b0;

		if (settled && (raw != stable_q)) begin
			stable_n = raw;
			if (!raw) begin
				press_n     = req.now_ms;
				long_done_n = 1'b0;
			end else if (!long_done_q &&
			             (held < {{(TsW-DbW){1'b0}}, cfg.hold_time})) begin
				if (group_inc > {1'b0, cfg.group_max}) begin
					group_n = GroupFirst;
				end else begin
					group_n = group_inc[GroupW-1:0];
				end
				ev = EV_GROUP;
			end
		end

		// long-press check sees this poll's stable level and press start
		if (settled) begin
			go_long = !stable_n && !long_done_n &&
			          ((req.now_ms - press_n) >= {{(TsW-DbW){1'b0}}, cfg.hold_time});
		end

		if (go_long) begin
			long_done_n = 1'b1;
			unique case (mode_q)
				MD_LOCAL: begin
					mode_n = MD_REMOTE;
					ev     = EV_REMOTE;
					mact   = MACT_STOP;
				end
				MD_REMOTE: begin
					mode_n = MD_AUTO;
					ev     = EV_AUTO;
					mact   = MACT_STOP;
				end
				default: begin
					mode_n = MD_LOCAL;
					ev     = EV_READY;
					mact   = MACT_SPEAKER;
				end
			endcase
		end

		res.talk_group   = group_n;
		res.mode         = mode_n;
		res.mode_action  = mact;
		res.status_event = ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q  <= 1'b1;
			stable_q    <= 1'b1;
			change_q    <= '0;
			press_q     <= '0;
			long_done_q <= 1'b0;
			group_q     <= GroupFirst;
			mode_q      <= MD_LOCAL;
		end else if (adv) begin
			prev_raw_q  <= raw;
			stable_q    <= stable_n;
			change_q    <= change_n;
			press_q     <= press_n;
			long_done_q <= long_done_n;
			group_q     <= group_n;
			mode_q      <= mode_n;
		end
	end

endmodule

FILE: sv/bdp_ptt.sv
// Push-to-talk: LED, transmit start/stop, gated by the mode after this poll.
// Depends on bdp_pkg.
`timescale 1ns / 1ps

module bdp_ptt (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              ptt_level,
	input  logic [1:0]        mode,
	output bdp_pkg::ptt_res_t res
);
	import bdp_pkg::*;

	logic tx_q;
	logic tx_n;
	logic pressed;

	always_comb begin
		pressed             = !ptt_level;
		tx_n                = tx_q;
		res.receiving_clear = 1'b0;
		res.ptt_action      = PACT_NONE;
		res.status_event    = EV_NONE;
		priority if (mode != MD_LOCAL) begin
			tx_n = 1'b0;
		end else if (pressed && !tx_q) begin
			tx_n                = 1'b1;
			res.receiving_clear = 1'b1;
			res.ptt_action      = PACT_MIC;
			res.status_event    = EV_TX;
		end else if (!pressed && tx_q) begin
			tx_n             = 1'b0;
			res.ptt_action   = PACT_SPEAKER;
			res.status_event = EV_READY;
		end else begin
			tx_n = tx_q;
		end
		res.ptt_led      = pressed;
		res.transmitting = tx_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_q <= 1'b0;
		end else if (adv) begin
			tx_q <= tx_n;
		end
	end

endmodule

FILE: tb/bdp_outcome_checker.sv
// Checker for button_debounce_press_control_core: watches the poll, result and
// configuration ports, predicts each poll's outcome and compares it field by field.
// Depends on bdp_pkg.
`timescale 1ns / 1ps

module bdp_outcome_checker
	import bdp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  in_req_t             in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  out_req_t            out_data,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output int                  fail_count,
	output int                  pending
);

	// shadow registers
	logic [DbW-1:0]    quiet_ms;
	logic [DbW-1:0]    hold_ms;
	logic [GroupW-1:0] group_limit;

	// shadow state
	logic              fn_prev;
	logic              fn_stable;
	logic [TsW-1:0]    change_t;
	logic [TsW-1:0]    press_t;
	logic              long_seen;
	logic [GroupW-1:0] group;
	logic [1:0]        mode;
	logic              tx_on;

	out_req_t outcome_q[$];
	out_req_t want;
	int       errors  = 0;
	int       waiting = 0;

	assign fail_count = errors;
	assign pending    = waiting;

	function automatic out_req_t poll_outcome(in_req_t p);
		logic          ptt_down;
		logic [TsW-1:0] held;
		logic [GroupW:0] nxt;
		out_req_t      r;
		r = '0;
		ptt_down = ~p.ptt_level;

		// function button
		if (p.fn_level != fn_prev)
			change_t = p.now_ms;
		if (TsW'(p.now_ms - change_t) > TsW'(quiet_ms)) begin
			if (p.fn_level != fn_stable) begin
				fn_stable = p.fn_level;
				held = p.now_ms - press_t;
				if (!fn_stable) begin
					press_t   = p.now_ms;
					long_seen = 1'b0;
				end else if (!long_seen && held < TsW'(hold_ms)) begin
					nxt = {1'b0, group} + 1'b1;
					if (nxt > {1'b0, group_limit})
						nxt = {1'b0, GroupFirst};
					group = nxt[GroupW-1:0];
					r.status_event = EV_GROUP;
				end
			end
			held = p.now_ms - press_t;
			if (!fn_stable && !long_seen && held >= TsW'(hold_ms)) begin
				case (mode)
					MD_LOCAL: begin
						mode = MD_REMOTE;
						r.status_event = EV_REMOTE;
						r.mode_action  = MACT_STOP;
					end
					MD_REMOTE: begin
						mode = MD_AUTO;
						r.status_event = EV_AUTO;
						r.mode_action  = MACT_STOP;
					end
					default: begin
						mode = MD_LOCAL;
						r.status_event = EV_READY;
						r.mode_action  = MACT_SPEAKER;
					end
				endcase
				long_seen = 1'b1;
			end
		end
		fn_prev = p.fn_level;

		// push-to-talk, sees this poll's mode
		if (mode != MD_LOCAL) begin
			tx_on = 1'b0;
		end else if (ptt_down && !tx_on) begin
			tx_on = 1'b1;
			r.receiving_clear = 1'b1;
			r.status_event    = EV_TX;
			r.ptt_action      = PACT_MIC;
		end else if (!ptt_down && tx_on) begin
			tx_on = 1'b0;
			r.status_event = EV_READY;
			r.ptt_action   = PACT_SPEAKER;
		end

		r.talk_group   = group;
		r.mode         = mode;
		r.ptt_led      = ptt_down;
		r.transmitting = tx_on;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_ms    = DebounceRst;
			hold_ms     = LongRst;
			group_limit = MaxGroupRst;
			fn_prev     = 1'b1;
			fn_stable   = 1'b1;
			change_t    = '0;
			press_t     = '0;
			long_seen   = 1'b0;
			group       = GroupFirst;
			mode        = MD_LOCAL;
			tx_on       = 1'b0;
			outcome_q.delete();
			waiting <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_DEBOUNCE:  quiet_ms    = cfg_data[DbW-1:0];
					CFG_LONG:      hold_ms     = cfg_data[DbW-1:0];
					CFG_MAX_GROUP: group_limit = cfg_data[GroupW-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (outcome_q.size() == 0) begin
					$error("result request with no poll outstanding");
					errors++;
				end else begin
					want = outcome_q.pop_front();
					check_field("talk_group", 32'(want.talk_group),
						32'(out_data.talk_group));
					check_field("mode", 32'(want.mode), 32'(out_data.mode));
					check_field("ptt_led", 32'(want.ptt_led), 32'(out_data.ptt_led));
					check_field("transmitting", 32'(want.transmitting),
						32'(out_data.transmitting));
					check_field("receiving_clear", 32'(want.receiving_clear),
						32'(out_data.receiving_clear));
					check_field("mode_action", 32'(want.mode_action),
						32'(out_data.mode_action));
					check_field("ptt_action", 32'(want.ptt_action),
						32'(out_data.ptt_action));
					check_field("status_event", 32'(want.status_event),
						32'(out_data.status_event));
				end
			end
			if (in_valid && !in_stall)
				outcome_q.push_back(poll_outcome(in_data));
			waiting <= outcome_q.size();
		end
	end

endmodule

FILE: tb/tb_button_debounce_press_control_core.sv
// Testbench top for button_debounce_press_control_core: drives polls, result stalls
// and register writes, and gives the verdict. Prediction lives in bdp_outcome_checker.
// Depends on bdp_pkg, the core and bdp_outcome_checker.
`timescale 1ns / 1ps

module tb_button_debounce_press_control_core;
	import bdp_pkg::*;

	// index past the register file; writes to it must be dropped
	localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

	localparam int StallPct    = 35;   // idle / stall odds, in percent
	localparam int PttFlipPct  = 15;   // chance the ptt level flips on a poll
	localparam int NoisePct    = 15;   // chance a phase step is a noise poll rather than a press gesture
	localparam int PhaseItems  = 240;  // minimum polls per configuration phase
	localparam int DrainCycles = 8;    // settle time after the last result
	localparam int IdleLimit   = 4000; // cycles with no request moving before giving up

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	in_req_t             in_data   = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	out_req_t            out_data;
	logic                cfg_we    = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = CFG_DEBOUNCE;
	logic [CfgDataW-1:0] cfg_data  = '0;

	int fail_count;
	int pending;

	// stimulus bookkeeping
	logic           calm     = 1'b0;   // no idling on either side while set
	logic [TsW-1:0] cur_time = '0;
	logic           fn_raw   = 1'b1;
	logic           ptt_raw  = 1'b1;
	int unsigned    db_ms    = 32'(DebounceRst);
	int unsigned    long_ms  = 32'(LongRst);
	int             sent     = 0;
	int             quiet_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	button_debounce_press_control_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	bdp_outcome_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	// Result side: random back-pressure, none during the calm phase.
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < StallPct);
	end

	// Watchdog: any request moving on either channel restarts the count.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= IdleLimit) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// One poll request at absolute time t. Random idle cycles go in front of it;
	// the stall is looked at on the falling edge, where everything has settled.
	task automatic send_poll(input logic fn, input logic ptt, input logic [TsW-1:0] t);
		in_req_t req;
		req.fn_level  = fn;
		req.ptt_level = ptt;
		req.now_ms    = t;
		cur_time      = t;
		while (!calm && $urandom_range(0, 99) < StallPct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		@(posedge clk);
		sent++;
	endtask

	// Poll with the button at fn, dt ms after the last one; ptt wanders on its own.
	task automatic poll_fn(input logic fn, input int unsigned dt);
		if ($urandom_range(0, 99) < PttFlipPct)
			ptt_raw = ~ptt_raw;
		fn_raw = fn;
		send_poll(fn, ptt_raw, cur_time + dt);
	endtask

	// Gap after the last edge: right on the debounce boundary, just past it,
	// well past it, or too short so the next poll has to finish the job.
	function automatic int unsigned quiet_gap();
		case ($urandom_range(0, 3))
			0:       return db_ms;
			1:       return db_ms + 1;
			2:       return db_ms + $urandom_range(2, 300);
			default: return $urandom_range(0, db_ms);
		endcase
	endfunction

	// Contact chatter that never lasts long enough to count, then a clean
	// level and a quiet gap.
	task automatic chatter_then(input logic level);
		int n;
		n = $urandom_range(0, 3);
		repeat (n)
			poll_fn(~fn_raw, $urandom_range(0, db_ms));
		poll_fn(level, $urandom_range(0, db_ms));
		poll_fn(level, quiet_gap());
	endtask

	// A full press: bouncy make, a hold that is short, on the long-press
	// boundary or long, bouncy break, then some idle polls.
	task automatic press_gesture();
		int unsigned hold;
		int          n;
		chatter_then(1'b0);
		case ($urandom_range(0, 3))
			0:       hold = (long_ms > 0) ? $urandom_range(0, long_ms - 1) : 0;
			1:       hold = (long_ms > 0) ? long_ms - 1 : 0;
			2:       hold = long_ms;
			default: hold = long_ms + $urandom_range(1, 2000);
		endcase
		n = $urandom_range(1, 4);
		repeat (n)
			poll_fn(1'b0, hold / n);
		chatter_then(1'b1);
		n = $urandom_range(0, 2);
		repeat (n)
			poll_fn(1'b1, $urandom_range(0, db_ms + 50));
	endtask

	// Unstructured poll: random levels, and now and then a jump to any time at all.
	task automatic noise_poll();
		logic [TsW-1:0] t;
		if ($urandom_range(0, 24) == 0)
			t = $urandom;
		else
			t = cur_time + $urandom_range(0, 2 * db_ms + 2);
		fn_raw  = 1'($urandom_range(0, 1));
		ptt_raw = 1'($urandom_range(0, 1));
		send_poll(fn_raw, ptt_raw, t);
	endtask

	task automatic run_phase();
		int first;
		first = sent;
		while (sent - first < PhaseItems) begin
			if ($urandom_range(0, 99) < NoisePct)
				noise_poll();
			else
				press_gesture();
		end
	endtask

	// Sender holds off until every result request of the phase has come back.
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	// Register writes, block idle. Optionally pokes the unused index first.
	task automatic apply_settings(input logic [DbW-1:0] db, input logic [DbW-1:0] lp,
			input logic [GroupW-1:0] top_group, input logic poke_unused);
		if (poke_unused) begin
			cfg_we    <= 1'b1;
			cfg_index <= CFG_UNUSED;
			cfg_data  <= CfgDataW'($urandom);
			@(posedge clk);
		end
		cfg_we    <= 1'b1;
		cfg_index <= CFG_DEBOUNCE;
		cfg_data  <= db;
		@(posedge clk);
		cfg_index <= CFG_LONG;
		cfg_data  <= lp;
		@(posedge clk);
		cfg_index <= CFG_MAX_GROUP;
		cfg_data  <= CfgDataW'(top_group);
		@(posedge clk);
		cfg_we  <= 1'b0;
		db_ms   = 32'(db);
		long_ms = 32'(lp);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed polls at reset settings (debounce 50, long 1000, 16 groups).
		send_poll(1'b1, 1'b1, 32'd0);           // nothing happening, time zero
		send_poll(1'b1, 1'b0, 32'd10);          // ptt down: transmit start
		send_poll(1'b1, 1'b1, 32'd20);          // ptt up: transmit stop
		send_poll(1'b0, 1'b1, 32'd100);         // button edge, not yet stable
		send_poll(1'b0, 1'b1, 32'd151);         // stable press
		send_poll(1'b1, 1'b1, 32'd300);
		send_poll(1'b1, 1'b1, 32'd351);         // short release: next group
		send_poll(1'b0, 1'b0, 32'd400);         // press while transmitting
		send_poll(1'b0, 1'b0, 32'd451);
		send_poll(1'b0, 1'b0, 32'd1451);        // long: remote, transmit forced off
		send_poll(1'b1, 1'b1, 32'd1500);
		send_poll(1'b1, 1'b1, 32'd1551);        // release after long: no group step
		send_poll(1'b0, 1'b0, 32'd1600);        // ptt ignored outside local mode
		send_poll(1'b0, 1'b1, 32'd1651);
		send_poll(1'b0, 1'b1, 32'd2651);        // long: auto
		send_poll(1'b1, 1'b1, 32'd2700);
		send_poll(1'b1, 1'b1, 32'd2800);
		send_poll(1'b0, 1'b0, 32'd2900);
		send_poll(1'b0, 1'b0, 32'd2951);
		send_poll(1'b0, 1'b0, 32'd3951);        // long back to local, ptt status wins
		send_poll(1'b1, 1'b1, 32'd4000);
		send_poll(1'b1, 1'b1, 32'd4051);
		send_poll(1'b0, 1'b1, 32'hFFFF_FFF0);   // time jump near the top
		send_poll(1'b0, 1'b1, 32'hFFFF_FFFF);   // all-ones time, still bouncing
		send_poll(1'b0, 1'b1, 32'h0000_0030);   // stable across the wrap
		fn_raw  = 1'b0;
		ptt_raw = 1'b1;

		run_phase();
		drain();

		// lowest settings, no idling anywhere
		apply_settings(16'd0, 16'd1, 8'd1, 1'b0);
		calm = 1'b1;
		run_phase();
		drain();
		calm = 1'b0;

		// highest settings
		apply_settings(16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);
		run_phase();
		drain();

		// moderate random settings; the unused index write must change nothing
		apply_settings(DbW'($urandom_range(0, 200)), DbW'($urandom_range(1, 3000)),
			GroupW'($urandom_range(1, 255)), 1'b1);
		run_phase();
		drain();

		// zero hold time makes every press long; with zero group limit any group step would wrap to group 1
		apply_settings(16'd5, 16'd0, 8'd0, 1'b0);
		run_phase();
		drain();

		// wide random timing, few groups so wrapping is frequent
		apply_settings(DbW'($urandom_range(0, 65535)), DbW'($urandom_range(1, 65535)),
			GroupW'($urandom_range(2, 8)), 1'b1);
		run_phase();
		drain();

		repeat (DrainCycles) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
